// File: rtl/rti_pkg.sv
// Shared constants for the ray/triangle intersection pipeline.
// No dependencies.
`default_nettype none
package rti_pkg;
	localparam int FIELD_W = 60;
	localparam int THR_W   = 16;
	localparam int DIST_W  = 24;
	localparam int BARY_W  = 13;
endpackage
`default_nettype wire

// File: rtl/ray_triangle_intersect.sv
// Ray/triangle intersection (one-sided Moller-Trumbore), fully pipelined.
// Input side: in_valid/in_stall; one word holds a ray and a triangle.
// Output side: out_valid/out_stall; one word holds hit, distance, weights.
// Configuration: cfg_valid/cfg_ready/cfg_data writes det_threshold; always ready.
// Throughput: one word per cycle while out_stall does not hold the pipe. Stages at default parameters
// (diff, cross product 2, dot product 3, decision 1, divider 24, output 1).
// The divider retires one quotient bit per stage, which sets the depth.
// Reset clears all valid bits and det_threshold; payload registers are not reset.
// While out_valid is high and out_stall is high the whole pipe holds and
// in_stall is raised; no word is dropped or repeated.
// Depends on rti_pkg, rti_dot, rti_div.
`default_nettype none
module ray_triangle_intersect #(
	parameter int COORD_BITS = 20,
	parameter int FRAC_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rti_pkg::FIELD_W-1:0]   ray_origin,
	input  logic [rti_pkg::FIELD_W-1:0]   ray_dir,
	input  logic [rti_pkg::FIELD_W-1:0]   vertex_a,
	input  logic [rti_pkg::FIELD_W-1:0]   vertex_b,
	input  logic [rti_pkg::FIELD_W-1:0]   vertex_c,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic [rti_pkg::DIST_W-1:0]    hit_distance,
	output logic [rti_pkg::BARY_W-1:0]    bary_zero,
	output logic [rti_pkg::BARY_W-1:0]    bary_one,
	output logic [rti_pkg::BARY_W-1:0]    bary_two,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rti_pkg::THR_W-1:0]     cfg_data
);
	localparam int C  = COORD_BITS;
	localparam int DW = C + 1;
	localparam int CW = 2 * DW + 1;
	localparam int SW = DW + CW + 2;
	localparam int QT = rti_pkg::DIST_W;
	localparam int BW = rti_pkg::BARY_W;
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	logic [rti_pkg::THR_W-1:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	// unpack
	logic [3*C-1:0] org_w, dir_w, va_w, vb_w, vc_w;
	assign org_w = (3*C)'(ray_origin);
	assign dir_w = (3*C)'(ray_dir);
	assign va_w  = (3*C)'(vertex_a);
	assign vb_w  = (3*C)'(vertex_b);
	assign vc_w  = (3*C)'(vertex_c);

	logic signed [DW-1:0] org_c [3], dir_c [3], va_c [3], vb_c [3], vc_c [3];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			org_c[j] = DW'($signed(org_w[j*C +: C]));
			dir_c[j] = DW'($signed(dir_w[j*C +: C]));
			va_c[j]  = DW'($signed(va_w[j*C +: C]));
			vb_c[j]  = DW'($signed(vb_w[j*C +: C]));
			vc_c[j]  = DW'($signed(vc_w[j*C +: C]));
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [DW-1:0]   e1_s1 [3], e2_s1 [3], s_s1 [3], dir_s1 [3];
	logic signed [DW-1:0]   e1_s2 [3], e2_s2 [3], s_s2 [3], dir_s2 [3];
	logic signed [DW-1:0]   e1_s3 [3], e2_s3 [3], s_s3 [3], dir_s3 [3];
	logic signed [2*DW-1:0] qa_s2 [3], qb_s2 [3], ra_s2 [3], rb_s2 [3];
	logic signed [CW-1:0]   q_s3 [3], r_s3 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				e1_s1[j]  <= vb_c[j] - va_c[j];
				e2_s1[j]  <= vc_c[j] - va_c[j];
				s_s1[j]   <= org_c[j] - va_c[j];
				dir_s1[j] <= dir_c[j];
				e1_s2[j]  <= e1_s1[j];
				e2_s2[j]  <= e2_s1[j];
				s_s2[j]   <= s_s1[j];
				dir_s2[j] <= dir_s1[j];
				qa_s2[j]  <= dir_s1[(j+1)%3] * e2_s1[(j+2)%3];
				qb_s2[j]  <= dir_s1[(j+2)%3] * e2_s1[(j+1)%3];
				ra_s2[j]  <= s_s1[(j+1)%3] * e1_s1[(j+2)%3];
				rb_s2[j]  <= s_s1[(j+2)%3] * e1_s1[(j+1)%3];
				e1_s3[j]  <= e1_s2[j];
				e2_s3[j]  <= e2_s2[j];
				s_s3[j]   <= s_s2[j];
				dir_s3[j] <= dir_s2[j];
				q_s3[j]   <= CW'(qa_s2[j]) - CW'(qb_s2[j]);
				r_s3[j]   <= CW'(ra_s2[j]) - CW'(rb_s2[j]);
			end
		end
	end

	logic signed [SW-1:0] det_s6, u_s6, v_s6, tn_s6;
	rti_dot #(.DW(DW), .CW(CW)) u_dot_det (.clk, .en, .a(e1_s3),  .b(q_s3), .dot(det_s6));
	rti_dot #(.DW(DW), .CW(CW)) u_dot_u   (.clk, .en, .a(s_s3),   .b(q_s3), .dot(u_s6));
	rti_dot #(.DW(DW), .CW(CW)) u_dot_v   (.clk, .en, .a(dir_s3), .b(r_s3), .dot(v_s6));
	rti_dot #(.DW(DW), .CW(CW)) u_dot_tn  (.clk, .en, .a(e2_s3),  .b(r_s3), .dot(tn_s6));

	// hit decision and distance saturation
	logic [SW-1:0]        thr_ext;
	logic signed [SW:0]   uv_sum;
	logic [SW+QT-1:0]     sat_lim;
	logic                 det_gt, tn_pos, uv_gt, hit_c, sat_c;
	always_comb begin
		thr_ext = SW'(thr_q) << FRAC_BITS;
		uv_sum  = (SW+1)'(u_s6) + (SW+1)'(v_s6);
		uv_gt   = uv_sum > (SW+1)'(det_s6);
		det_gt  = !det_s6[SW-1] && ($unsigned(det_s6) > thr_ext);
		tn_pos  = !tn_s6[SW-1] && (tn_s6 != '0);
		hit_c   = det_gt && !u_s6[SW-1] && !v_s6[SW-1] && !uv_gt && tn_pos;
		sat_lim = (SW+QT)'($unsigned(det_s6)) << (QT - FRAC_BITS);
		sat_c   = (SW+QT)'($unsigned(tn_s6)) >= sat_lim;
	end

	logic          hit_s7, sat_s7;
	logic [SW-1:0] det_s7, u_s7, v_s7, tn_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s7 <= hit_c;
			sat_s7 <= sat_c;
			det_s7 <= $unsigned(det_s6);
			u_s7   <= $unsigned(u_s6);
			v_s7   <= $unsigned(v_s6);
			tn_s7  <= $unsigned(tn_s6);
		end
	end

	logic [QT-1:0] qt_d, qu_d, qv_d;
	rti_div #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div_t (.clk, .en, .n(tn_s7), .d(det_s7), .q(qt_d));
	rti_div #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div_u (.clk, .en, .n(u_s7),  .d(det_s7), .q(qu_d));
	rti_div #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div_v (.clk, .en, .n(v_s7),  .d(det_s7), .q(qv_d));

	logic [QT-1:0] vld_sd, hit_sd, sat_sd;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
			vld_sd    <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_sd    <= {vld_sd[QT-2:0], vld_s7};
			out_valid <= vld_sd[QT-1];
		end
	end

	logic [BW-1:0] b1_c, b2_c;
	assign b1_c = qu_d[BW-1:0];
	assign b2_c = qv_d[BW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hit_sd <= {hit_sd[QT-2:0], hit_s7};
			sat_sd <= {sat_sd[QT-2:0], sat_s7};
			hit    <= hit_sd[QT-1];
			if (hit_sd[QT-1]) begin
				hit_distance <= sat_sd[QT-1] ? '1 : qt_d;
				bary_one     <= b1_c;
				bary_two     <= b2_c;
				bary_zero    <= ONE[BW-1:0] - b1_c - b2_c;
			end else begin
				hit_distance <= '1;
				bary_one     <= '0;
				bary_two     <= '0;
				bary_zero    <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/rti_dot.sv
// Three-stage pipelined signed dot product of two 3-vectors.
// Wide operand split in halves; no package or module dependencies.
`default_nettype none
module rti_dot #(
	parameter int DW = 21,
	parameter int CW = 43
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [DW-1:0]       a [3],
	input  logic signed [CW-1:0]       b [3],
	output logic signed [DW+CW+1:0]    dot
);
	localparam int LB = CW / 2;
	localparam int HB = CW - LB;
	localparam int PW = DW + CW;
	localparam int SW = PW + 2;

	logic signed [DW+LB:0]   plo_s1 [3];
	logic signed [DW+HB-1:0] phi_s1 [3];
	logic signed [PW-1:0]    term_s2 [3];
	logic signed [SW-1:0]    dot_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				plo_s1[j]  <= a[j] * $signed({1'b0, b[j][LB-1:0]});
				phi_s1[j]  <= a[j] * $signed(b[j][CW-1:LB]);
				term_s2[j] <= (PW'(phi_s1[j]) <<< LB) + PW'(plo_s1[j]);
			end
			dot_s3 <= SW'(term_s2[0]) + SW'(term_s2[1]) + SW'(term_s2[2]);
		end
	end

	assign dot = dot_s3;
endmodule
`default_nettype wire

// File: rtl/rti_div.sv
// Pipelined restoring divider, one quotient bit per stage: floor(n*2^F/d).
// Depends on rti_pkg for the quotient width.
`default_nettype none
module rti_div #(
	parameter int SW = 66,
	parameter int FRAC_BITS = 12
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [SW-1:0]               n,
	input  logic [SW-1:0]               d,
	output logic [rti_pkg::DIST_W-1:0]  q
);
	localparam int QT = rti_pkg::DIST_W;
	localparam int RW = SW + QT;

	logic [RW-1:0] rem_q [QT];
	logic [SW-1:0] d_q   [QT];
	logic [QT-1:0] quo_q [QT];

	for (genvar k = 0; k < QT; k++) begin : g_stage
		logic [RW-1:0] rem_in;
		logic [SW-1:0] d_in;
		logic [QT-1:0] quo_in;
		logic [RW:0]   trial;
		if (k == 0) begin : g_first
			assign rem_in = RW'(n) << FRAC_BITS;
			assign d_in   = d;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign d_in   = d_q[k-1];
			assign quo_in = quo_q[k-1];
		end
		assign trial = {1'b0, rem_in} - ((RW+1)'(d_in) << (QT - 1 - k));
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= trial[RW] ? rem_in : trial[RW-1:0];
				d_q[k]   <= d_in;
				quo_q[k] <= {quo_in[QT-2:0], ~trial[RW]};
			end
		end
	end

	assign q = quo_q[QT-1];
endmodule
`default_nettype wire

// File: rtl/rti_checker.sv
// Port-level checks for ray_triangle_intersect, bound to the top level.
// Depends on rti_pkg.
`default_nettype none
module rti_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        hit,
	input logic [rti_pkg::DIST_W-1:0]  hit_distance,
	input logic [rti_pkg::BARY_W-1:0]  bary_zero,
	input logic [rti_pkg::BARY_W-1:0]  bary_one,
	input logic [rti_pkg::BARY_W-1:0]  bary_two
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_distance))
		else $error("stalled output word changed");

	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_distance == '1)
		else $error("miss without all-ones distance");

	a_miss_bary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> bary_zero == '0 && bary_one == '0 && bary_two == '0)
		else $error("miss with nonzero weights");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");
endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (.*);
`default_nettype wire

// File: verif/ray_triangle_intersect_tb.sv
// Testbench for ray_triangle_intersect: random and constructed ray/triangle words,
// checked against an exact wide-integer intersection predictor in a scoreboard class.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
module ray_triangle_intersect_tb;
	localparam int LIMIT   = 400000;
	localparam int LATENCY = 32;
	localparam int CB      = 20;
	localparam int FB      = 12;

	typedef longint vec3_t[3];
	typedef struct packed {
		logic                       hit;
		logic [rti_pkg::DIST_W-1:0] tdist;
		logic [rti_pkg::BARY_W-1:0] b0;
		logic [rti_pkg::BARY_W-1:0] b1;
		logic [rti_pkg::BARY_W-1:0] b2;
	} isect_t;

	class intersect_scoreboard;
		isect_t                    expected_q[$];
		logic [rti_pkg::THR_W-1:0] thr;
		int                        errors, checked, hits;

		function longint coord(logic [rti_pkg::FIELD_W-1:0] p, int i);
			logic signed [CB-1:0] c;
			c = p[i*CB +: CB];
			return longint'(c);
		endfunction

		function logic signed [127:0] dot(vec3_t a, vec3_t b);
			logic signed [127:0] acc, x, y;
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				x = a[i];
				y = b[i];
				acc += x * y;
			end
			return acc;
		endfunction

		function logic [63:0] div_sat(logic signed [127:0] n, logic signed [127:0] d,
				logic [63:0] cap);
			logic [127:0] qq;
			qq = (128'(n) << FB) / 128'(d);
			return (qq > cap) ? cap : qq[63:0];
		endfunction

		function isect_t predict(logic [rti_pkg::FIELD_W-1:0] fo, fd, fa, fb, fc);
			vec3_t o, d, va, vb, vc, e1, e2, s, q, r;
			logic signed [127:0] det, u, v, tn, thrw;
			isect_t res;
			logic [63:0] w1, w2, w0, t64;
			for (int i = 0; i < 3; i++) begin
				o[i] = coord(fo, i); d[i] = coord(fd, i);
				va[i] = coord(fa, i); vb[i] = coord(fb, i); vc[i] = coord(fc, i);
				e1[i] = vb[i] - va[i]; e2[i] = vc[i] - va[i]; s[i] = o[i] - va[i];
			end
			q[0] = d[1]*e2[2] - d[2]*e2[1];
			q[1] = d[2]*e2[0] - d[0]*e2[2];
			q[2] = d[0]*e2[1] - d[1]*e2[0];
			r[0] = s[1]*e1[2] - s[2]*e1[1];
			r[1] = s[2]*e1[0] - s[0]*e1[2];
			r[2] = s[0]*e1[1] - s[1]*e1[0];
			det = dot(e1, q);
			u = dot(s, q);
			v = dot(d, r);
			tn = dot(e2, r);
			thrw = 0;
			thrw[rti_pkg::THR_W+FB-1:0] = {thr, {FB{1'b0}}};
			if (!(det > thrw) || u < 0 || v < 0 || (u + v) > det || tn <= 0) begin
				res = '{hit: 1'b0, tdist: '1, b0: '0, b1: '0, b2: '0};
			end else begin
				w1 = div_sat(u, det, 64'd1 << FB);
				w2 = div_sat(v, det, 64'd1 << FB);
				t64 = div_sat(tn, det, 64'hFFFFFF);
				w0 = (64'd1 << FB) - w1 - w2;
				res.hit = 1'b1;
				res.tdist = t64[rti_pkg::DIST_W-1:0];
				res.b1 = w1[rti_pkg::BARY_W-1:0];
				res.b2 = w2[rti_pkg::BARY_W-1:0];
				res.b0 = w0[rti_pkg::BARY_W-1:0];
			end
			return res;
		endfunction

		task note_input(logic [rti_pkg::FIELD_W-1:0] fo, fd, fa, fb, fc);
			expected_q = {expected_q, predict(fo, fd, fa, fb, fc)};
		endtask

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(isect_t got);
			isect_t want;
			if (expected_q.size() == 0) begin
				report("result word with nothing expected");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.hit) hits++;
			if (got.hit !== want.hit)
				report($sformatf("#%0d hit %0b exp %0b", checked, got.hit, want.hit));
			if (got.tdist !== want.tdist)
				report($sformatf("#%0d dist %h exp %h", checked, got.tdist, want.tdist));
			if (got.b0 !== want.b0)
				report($sformatf("#%0d bary0 %h exp %h", checked, got.b0, want.b0));
			if (got.b1 !== want.b1)
				report($sformatf("#%0d bary1 %h exp %h", checked, got.b1, want.b1));
			if (got.b2 !== want.b2)
				report($sformatf("#%0d bary2 %h exp %h", checked, got.b2, want.b2));
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_valid = 0;
	logic [rti_pkg::THR_W-1:0] cfg_data = '0;
	logic [rti_pkg::FIELD_W-1:0] ray_origin = '0, ray_dir = '0, vertex_a = '0,
		vertex_b = '0, vertex_c = '0;
	logic in_stall, out_valid, hit, cfg_ready;
	logic [rti_pkg::DIST_W-1:0] hit_distance;
	logic [rti_pkg::BARY_W-1:0] bary_zero, bary_one, bary_two;

	intersect_scoreboard sb = new();
	int cycles = 0, sent = 0, stall_left = 0;
	bit quiet = 0;

	ray_triangle_intersect dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.ray_origin(ray_origin), .ray_dir(ray_dir),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_distance(hit_distance),
		.bary_zero(bary_zero), .bary_one(bary_one), .bary_two(bary_two),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("ray_triangle_intersect_tb failed");
			$finish;
		end
	end

	// output side: check accepted words, random stall bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{hit, hit_distance, bary_zero, bary_one, bary_two});
		if (stall_left == 0 && !quiet && arst_n && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 13);
		out_stall <= (stall_left > 0);
		if (stall_left > 0) stall_left--;
	end

	function automatic logic [rti_pkg::FIELD_W-1:0] pack3(longint x, longint y, longint z);
		logic [CB-1:0] px, py, pz;
		px = x[CB-1:0]; py = y[CB-1:0]; pz = z[CB-1:0];
		return {pz, py, px};
	endfunction

	function automatic logic [rti_pkg::FIELD_W-1:0] rnd_field();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[rti_pkg::FIELD_W-1:0];
	endfunction

	function automatic longint srnd(int bits);
		return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (longint'(1) << bits);
	endfunction

	task automatic send(logic [rti_pkg::FIELD_W-1:0] fo, fd, fa, fb, fc);
		int g;
		g = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		ray_origin <= fo; ray_dir <= fd;
		vertex_a <= fa; vertex_b <= fb; vertex_c <= fc;
		do @(posedge clk); while (in_stall);
		sb.note_input(fo, fd, fa, fb, fc);
		sent++;
	endtask

	// ray aimed at a point in the triangle, winding fixed to face the ray; kind 1 then flips the winding, kind 2 the ray
	task automatic send_aimed(int kind);
		vec3_t a, b, c, o, t, d;
		int sc, w1, w2, sh;
		longint tmp;
		isect_t probe;
		sc = $urandom_range(2, 16);
		sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 3);
		w1 = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 256);
		w2 = ($urandom_range(0, 7) == 0) ? 256 - w1 : $urandom_range(0, 256 - w1);
		for (int i = 0; i < 3; i++) begin
			a[i] = srnd(15);
			b[i] = a[i] + srnd(sc);
			c[i] = a[i] + srnd(sc);
			o[i] = srnd(16);
			t[i] = a[i] + ((b[i] - a[i]) * w1 + (c[i] - a[i]) * w2) / 256;
			d[i] = (t[i] - o[i]) >>> sh;
		end
		probe = sb.predict(pack3(o[0], o[1], o[2]), pack3(d[0], d[1], d[2]),
			pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]),
			pack3(c[0], c[1], c[2]));
		if (probe.hit == 0) begin
			for (int i = 0; i < 3; i++) begin
				tmp = b[i]; b[i] = c[i]; c[i] = tmp;
			end
		end
		if (kind == 1)
			for (int i = 0; i < 3; i++) begin
				tmp = b[i]; b[i] = c[i]; c[i] = tmp;
			end
		if (kind == 2)
			for (int i = 0; i < 3; i++) d[i] = -d[i];
		send(pack3(o[0], o[1], o[2]), pack3(d[0], d[1], d[2]), pack3(a[0], a[1], a[2]),
			pack3(b[0], b[1], b[2]), pack3(c[0], c[1], c[2]));
	endtask

	task automatic write_thr(logic [rti_pkg::THR_W-1:0] val);
		cfg_valid <= 1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.thr = val;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic directed();
		logic [rti_pkg::FIELD_W-1:0] a, b, c, o, dn;
		localparam longint ONE = 4096;
		localparam longint MXP = (1 << (CB - 1)) - 1;
		localparam longint MXN = -(1 << (CB - 1));
		a = pack3(0, 0, 0); b = pack3(ONE, 0, 0); c = pack3(0, ONE, 0);
		dn = pack3(0, 0, -ONE);
		send('0, '0, '0, '0, '0);
		send('1, '1, '1, '1, '1);
		send(pack3(MXP, MXP, MXP), pack3(MXP, MXP, MXP), pack3(MXP, MXP, MXP),
			pack3(MXP, MXP, MXP), pack3(MXP, MXP, MXP));
		send(pack3(MXN, MXN, MXN), pack3(MXN, MXN, MXN), pack3(MXN, MXN, MXN),
			pack3(MXN, MXN, MXN), pack3(MXN, MXN, MXN));
		o = pack3(1024, 1024, ONE);
		send(o, dn, a, b, c);                                 // plain front hit
		send(o, dn, a, c, b);                                 // back face
		send(pack3(1024, 1024, -ONE), dn, a, b, c);           // triangle behind ray
		send(pack3(1024, 1024, 0), dn, a, b, c);              // origin on plane
		send(pack3(0, 1024, ONE), dn, a, b, c);               // on an edge
		send(pack3(0, 0, ONE), dn, a, b, c);                  // at a vertex
		send(pack3(2048, 2048, ONE), dn, a, b, c);            // on the far edge
		send(pack3(3000, 3000, ONE), dn, a, b, c);            // outside
		send(pack3(1024, 1024, MXP), pack3(0, 0, -1), a, b, c); // distance saturates
		send(o, dn, a, b, b);                                 // degenerate
		send(pack3(1, 1, MXP), pack3(0, 0, MXN), pack3(MXN, MXN, 0),
			pack3(MXP, MXN, 0), pack3(MXN, MXP, 0));
		send(pack3(MXP, MXN, MXP), pack3(MXN, MXP, MXN), pack3(MXP, MXN, MXN),
			pack3(MXN, MXP, MXP), pack3(MXP, MXP, MXN));
	endtask

	initial begin
		logic [rti_pkg::THR_W-1:0] thr_list[6];
		logic [31:0] rw;
		int r;
		thr_list = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000, 16'h0000};
		rw = $urandom;
		thr_list[3] = rw[rti_pkg::THR_W-1:0];
		rw = $urandom_range(0, 255);
		thr_list[5] = rw[rti_pkg::THR_W-1:0];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			quiet = (ph == 5);
			write_thr(thr_list[ph]);
			for (int n = 0; n < 122; n++) begin
				r = $urandom_range(0, 19);
				if (r < 14) send_aimed(0);
				else if (r < 16) send_aimed($urandom_range(1, 2));
				else send(rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field());
			end
		end
		drain();
		$display("%0d words sent, %0d checked, %0d hits, thresholds 0 to ffff",
			sent, sb.checked, sb.hits);
		if (sb.errors == 0)
			$display("ray_triangle_intersect_tb passed");
		else
			$display("ray_triangle_intersect_tb failed");
		$finish;
	end
endmodule
